// ===== design/pasc_pkg.sv =====
// shared constants and types for the pitot airspeed block
package pasc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int RAW_BITS    = 14;

  localparam int MAG_W  = 16;
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [MAG_W:0] RAW_FULL = (MAG_W + 1)'((1 << RAW_BITS) - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CALIB_WINDOW = 2'd0,
    REG_ALPHA        = 2'd1,
    REG_SCALE        = 2'd2
  } reg_idx_t;

  localparam logic [15:0] CALIB_WINDOW_RST = 16'd3000;
  localparam logic [16:0] ALPHA_RST        = 17'd6554;
  localparam logic [15:0] SCALE_RST        = 16'd56288;

  localparam logic [16:0]       ALPHA_ONE  = 17'd65536;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = 32;
  localparam int STEP_W     = 5;
  localparam logic [31:0] SQRT_TOP = 32'h4000_0000;

endpackage

// ===== design/pasc_if.sv =====
// handshake channels for sensor frames and airspeed results
interface pasc_in_if;
  logic        valid;
  logic        ready;
  logic        read_ok;
  logic [7:0]  byte_high;
  logic [7:0]  byte_low;
  logic [31:0] time_ms;

  modport source (output valid, read_ok, byte_high, byte_low, time_ms, input ready);
  modport sink   (input valid, read_ok, byte_high, byte_low, time_ms, output ready);
endinterface

interface pasc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] airspeed;
  logic        calibrated;
  logic        frame_used;

  modport source (output valid, airspeed, calibrated, frame_used, input ready);
  modport sink   (input valid, airspeed, calibrated, frame_used, output ready);
endinterface

// ===== design/pitot_airspeed_calibrate_smooth.sv =====
// pitot airspeed: pressure to speed, zero-offset calibration and ema smoothing
//
//  channel   dir  beat contents                                  handshake
//  frame     in   read_ok, byte_high, byte_low, time_ms           valid/ready
//  result    out  airspeed, calibrated, frame_used                valid/ready
//  config    in   write_index, write_data                         write_en only
//
// an ignored frame goes straight to the result; a used frame runs the 16-step square
// root, and the frame that closes the calibration window adds the 32-step divider,
// both on a one-bit-a-cycle loop; a smoothed frame adds the ema multiply steps
// one frame is in flight at a time; frame.ready is high only while idle
// the result sits in an output register, so a new frame is taken while it waits
// rst is synchronous: clears calibration, smoothing and loads the register defaults
module pitot_airspeed_calibrate_smooth (
  input  logic                            clk,
  input  logic                            rst,
  pasc_in_if.sink                         frame,
  pasc_out_if.source                      result,
  input  logic                            write_en,
  input  logic [pasc_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [pasc_pkg::CFG_W-1:0]      write_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SQRT,
    S_UPDATE,
    S_DIV,
    S_DIVEND,
    S_EMA_A,
    S_EMA_B,
    S_EMA_C,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] calib_window_ms;
  logic [16:0] smoothing_alpha;
  logic [15:0] speed_scale;

  // architectural state
  logic                              offset_ready;
  logic                              window_open;
  logic [31:0]                       window_start;
  logic [31:0]                       speed_sum;
  logic [pasc_pkg::COUNT_WIDTH-1:0]  sample_count;
  logic [15:0]                       zero_offset;
  logic [15:0]                       smoothed_speed;
  logic                              smoothing_started;

  // per-frame working registers
  logic                              used;
  logic [pasc_pkg::MAG_W-1:0]        mag;
  logic [31:0]                       now;
  logic [pasc_pkg::STEP_W-1:0]       step;
  logic [31:0]                       sq_v;
  logic [31:0]                       sq_res;
  logic [31:0]                       sq_bit;
  logic [31:0]                       dv_q;
  logic [pasc_pkg::COUNT_WIDTH-1:0]  dv_rem;
  logic [15:0]                       x;
  logic [pasc_pkg::PROD_W-1:0]       prod;
  logic [pasc_pkg::PROD_W-1:0]       acc;

  // output register
  logic        out_valid;
  logic [15:0] out_airspeed;
  logic        out_calibrated;
  logic        out_frame_used;

  assign frame.ready       = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.airspeed   = out_airspeed;
  assign result.calibrated = out_calibrated;
  assign result.frame_used = out_frame_used;

  // frame decode at accept: status 2 or 3 or a failed read drops the frame
  logic                         in_used;
  logic [13:0]                  raw;
  logic [pasc_pkg::MAG_W:0]     twice;
  logic [pasc_pkg::MAG_W:0]     mag_wide;

  assign in_used  = frame.read_ok && !frame.byte_high[7];
  assign raw      = {frame.byte_high[5:0], frame.byte_low};
  assign twice    = (pasc_pkg::MAG_W + 1)'({raw, 1'b0});
  assign mag_wide = (twice >= pasc_pkg::RAW_FULL) ? (twice - pasc_pkg::RAW_FULL)
                                                  : (pasc_pkg::RAW_FULL - twice);

  // shared multiplier, operands picked by the sequencer
  logic [16:0] alpha_cl;
  logic [16:0] alpha_inv;
  logic [pasc_pkg::MUL_W-1:0]  mul_a;
  logic [pasc_pkg::MUL_W-1:0]  mul_b;
  logic [pasc_pkg::PROD_W-1:0] mul_out;

  assign alpha_cl  = (smoothing_alpha > pasc_pkg::ALPHA_ONE) ? pasc_pkg::ALPHA_ONE
                                                             : smoothing_alpha;
  assign alpha_inv = pasc_pkg::ALPHA_ONE - alpha_cl;

  always_comb begin
    case (state)
      S_MUL: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, speed_scale};
      end
      S_EMA_A: begin
        mul_a = {1'b0, smoothed_speed};
        mul_b = alpha_inv;
      end
      S_EMA_B: begin
        mul_a = {1'b0, x};
        mul_b = alpha_cl;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // square root step: one result bit per cycle
  logic [32:0] sq_trial;
  logic        sq_take;

  assign sq_trial = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_take  = ({1'b0, sq_v} >= sq_trial);

  // restoring divide step: speed_sum / sample_count
  logic [pasc_pkg::COUNT_WIDTH:0] dv_trial;
  logic                           dv_take;

  assign dv_trial = {dv_rem, dv_q[31]};
  assign dv_take  = (dv_trial >= {1'b0, sample_count});

  // calibration bookkeeping for the update step
  logic [15:0]                      speed;
  logic [32:0]                      sum_wide;
  logic [31:0]                      sum_next;
  logic [pasc_pkg::COUNT_WIDTH-1:0] count_next;
  logic [31:0]                      start_eff;
  logic [31:0]                      elapsed;
  logic                             window_done;
  logic [15:0]                      x_val;

  assign speed     = sq_res[15:0];
  assign sum_wide  = {1'b0, speed_sum} + {17'b0, speed};
  assign start_eff = window_open ? window_start : now;
  assign elapsed   = now - start_eff;

  always_comb begin
    if (sample_count != pasc_pkg::COUNT_MAX) begin
      sum_next   = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
      count_next = sample_count + 1'b1;
    end else begin
      sum_next   = speed_sum;
      count_next = sample_count;
    end
  end

  assign window_done = (elapsed >= {16'b0, calib_window_ms}) && (count_next != '0);
  assign x_val       = (speed > zero_offset) ? (speed - zero_offset) : 16'd0;

  // ema tail: rounded q16 sum, saturated to 16 bits
  logic [pasc_pkg::PROD_W-1:0] ema_sum;
  logic [pasc_pkg::PROD_W-17:0] ema_r;

  assign ema_sum = acc + prod;
  assign ema_r   = ema_sum[pasc_pkg::PROD_W-1:16];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_window_ms <= pasc_pkg::CALIB_WINDOW_RST;
      smoothing_alpha <= pasc_pkg::ALPHA_RST;
      speed_scale     <= pasc_pkg::SCALE_RST;
    end else if (write_en) begin
      case (pasc_pkg::reg_idx_t'(write_index))
        pasc_pkg::REG_CALIB_WINDOW: calib_window_ms <= write_data[15:0];
        pasc_pkg::REG_ALPHA:        smoothing_alpha <= write_data[16:0];
        pasc_pkg::REG_SCALE:        speed_scale     <= write_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      offset_ready      <= 1'b0;
      window_open       <= 1'b0;
      window_start      <= '0;
      speed_sum         <= '0;
      sample_count      <= '0;
      zero_offset       <= '0;
      smoothed_speed    <= '0;
      smoothing_started <= 1'b0;
      out_valid         <= 1'b0;
      step              <= '0;
    end else begin
      // result beat taken; in S_DONE the register is reloaded below instead
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (frame.valid) begin
            used  <= in_used;
            mag   <= mag_wide[pasc_pkg::MAG_W-1:0];
            now   <= frame.time_ms;
            state <= in_used ? S_MUL : S_DONE;
          end
        end

        S_MUL: begin
          sq_v   <= mul_out[31:0];
          sq_res <= '0;
          sq_bit <= pasc_pkg::SQRT_TOP;
          step   <= '0;
          state  <= S_SQRT;
        end

        S_SQRT: begin
          if (sq_take) begin
            sq_v   <= sq_v - sq_trial[31:0];
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          step   <= step + 1'b1;
          if (step == pasc_pkg::STEP_W'(pasc_pkg::SQRT_STEPS - 1)) begin
            state <= S_UPDATE;
          end
        end

        S_UPDATE: begin
          if (!offset_ready) begin
            if (!window_open) begin
              window_open  <= 1'b1;
              window_start <= now;
            end
            speed_sum    <= sum_next;
            sample_count <= count_next;
            if (window_done) begin
              dv_q   <= sum_next;
              dv_rem <= '0;
              step   <= '0;
              state  <= S_DIV;
            end else begin
              state <= S_DONE;
            end
          end else begin
            x <= x_val;
            if (!smoothing_started) begin
              smoothed_speed    <= x_val;
              smoothing_started <= 1'b1;
              state             <= S_DONE;
            end else begin
              state <= S_EMA_A;
            end
          end
        end

        S_DIV: begin
          dv_q   <= {dv_q[30:0], dv_take};
          dv_rem <= dv_take ? pasc_pkg::COUNT_WIDTH'(dv_trial - {1'b0, sample_count})
                            : dv_trial[pasc_pkg::COUNT_WIDTH-1:0];
          step   <= step + 1'b1;
          if (step == pasc_pkg::STEP_W'(pasc_pkg::DIV_STEPS - 1)) begin
            state <= S_DIVEND;
          end
        end

        S_DIVEND: begin
          zero_offset  <= (dv_q > 32'h0000_FFFF) ? 16'hFFFF : dv_q[15:0];
          offset_ready <= 1'b1;
          state        <= S_DONE;
        end

        S_EMA_A: begin
          prod  <= mul_out;
          state <= S_EMA_B;
        end

        S_EMA_B: begin
          acc   <= prod + pasc_pkg::ROUND_HALF;
          prod  <= mul_out;
          state <= S_EMA_C;
        end

        S_EMA_C: begin
          smoothed_speed <= (ema_r > (pasc_pkg::PROD_W - 16)'(16'hFFFF)) ? 16'hFFFF
                                                                          : ema_r[15:0];
          state          <= S_DONE;
        end

        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid || result.ready) begin
            out_valid      <= 1'b1;
            out_airspeed   <= offset_ready ? smoothed_speed : 16'd0;
            out_calibrated <= offset_ready;
            out_frame_used <= used;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
